[rtl/core/lpbw_pkg.sv]
// Shared types and constants for the long-press button watch core.
package lpbw_pkg;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_WARNING   = 3'd1,
        EV_FIRED     = 3'd2,
        EV_CANCELLED = 3'd3,
        EV_STUCK     = 3'd4
    } event_t;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_ARM_AFTER = 3'd1,
        REG_WARN      = 3'd2,
        REG_HOLD      = 3'd3,
        REG_STUCK     = 3'd4
    } reg_idx_t;

    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEB_W      = 16;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 40;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 16'd50;
    localparam logic [TIME_W-1:0] ARM_AFTER_RST = 32'd3000;
    localparam logic [TIME_W-1:0] WARN_RST      = 32'd2000;
    localparam logic [TIME_W-1:0] HOLD_RST      = 32'd10000;
    localparam logic [TIME_W-1:0] STUCK_RST     = 32'd30000;

endpackage

[rtl/core/long_press_button_watch_core.sv]
// Long-press button watch: debounce, boot window, warning/fired/cancelled/stuck events.
// A sample goes from the input register to the result register, which drives m_tvalid.
// Throughput: one sample per cycle while m_tready is not held low; the update is one pass
// through the state logic between the input register and the result register.
// While a result waits for m_tready, an empty input register still takes one transaction.
// Reset (aresetn low, synchronous): state cleared, registers back to their defaults.
module long_press_button_watch_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [0] pressed, [32:1] now_time, [39:33] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lpbw_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: [2:0] event_res, [34:3] held_time, [39:35] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpbw_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpbw_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // configuration
    logic [lpbw_pkg::DEB_W-1:0]  debounce_reg;
    logic [lpbw_pkg::TIME_W-1:0] arm_after_reg;
    logic [lpbw_pkg::TIME_W-1:0] warn_reg;
    logic [lpbw_pkg::TIME_W-1:0] hold_reg;
    logic [lpbw_pkg::TIME_W-1:0] stuck_reg;
    logic                        cfg_wr;
    lpbw_pkg::reg_idx_t          cfg_idx;

    // input register
    logic                        in_valid_reg;
    logic                        in_pressed_reg;
    logic [lpbw_pkg::TIME_W-1:0] in_now_reg;

    // detector state
    logic                        raw_reg, raw_next;
    logic [lpbw_pkg::TIME_W-1:0] chg_reg, chg_next;
    logic                        stable_reg, stable_next;
    logic                        deb_reg, deb_next;
    logic [lpbw_pkg::TIME_W-1:0] start_reg, start_next;
    logic                        armed_reg, armed_next;
    logic                        warned_reg, warned_next;
    logic                        fired_reg, fired_next;
    logic                        stuck_reg_f, stuck_next;
    logic [lpbw_pkg::TIME_W-1:0] held_reg, held_next;
    lpbw_pkg::event_t            ev_next;

    // result register
    logic                        out_valid_reg;
    lpbw_pkg::event_t            out_ev_reg;
    logic [lpbw_pkg::TIME_W-1:0] out_held_reg;

    logic                        advance;
    logic [lpbw_pkg::TIME_W-1:0] since_change;
    logic [lpbw_pkg::TIME_W-1:0] held_calc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = lpbw_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= lpbw_pkg::DEBOUNCE_RST;
            arm_after_reg <= lpbw_pkg::ARM_AFTER_RST;
            warn_reg      <= lpbw_pkg::WARN_RST;
            hold_reg      <= lpbw_pkg::HOLD_RST;
            stuck_reg     <= lpbw_pkg::STUCK_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                lpbw_pkg::REG_DEBOUNCE:  debounce_reg  <= pwdata[lpbw_pkg::DEB_W-1:0];
                lpbw_pkg::REG_ARM_AFTER: arm_after_reg <= pwdata;
                lpbw_pkg::REG_WARN:      warn_reg      <= pwdata;
                lpbw_pkg::REG_HOLD:      hold_reg      <= pwdata;
                lpbw_pkg::REG_STUCK:     stuck_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            lpbw_pkg::REG_DEBOUNCE:  prdata = {16'd0, debounce_reg};
            lpbw_pkg::REG_ARM_AFTER: prdata = arm_after_reg;
            lpbw_pkg::REG_WARN:      prdata = warn_reg;
            lpbw_pkg::REG_HOLD:      prdata = hold_reg;
            lpbw_pkg::REG_STUCK:     prdata = stuck_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    // handshake: input register drains when the result register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pressed_reg <= s_tdata[0];
            in_now_reg     <= s_tdata[32:1];
        end
    end

    assign since_change = in_now_reg - chg_reg;

    always_comb begin
        raw_next    = raw_reg;
        chg_next    = chg_reg;
        stable_next = stable_reg;
        deb_next    = deb_reg;
        start_next  = start_reg;
        armed_next  = armed_reg;
        warned_next = warned_reg;
        fired_next  = fired_reg;
        stuck_next  = stuck_reg_f;
        held_next   = held_reg;
        ev_next     = lpbw_pkg::EV_NONE;

        // debounce
        if (in_pressed_reg != raw_reg) begin
            raw_next    = in_pressed_reg;
            chg_next    = in_now_reg;
            stable_next = 1'b0;
        end else if (!stable_reg && since_change >= {16'd0, debounce_reg}) begin
            stable_next = 1'b1;
            if (deb_reg != raw_reg) begin
                deb_next = raw_reg;
                if (raw_reg) begin
                    start_next  = in_now_reg;
                    warned_next = 1'b0;
                    fired_next  = 1'b0;
                    stuck_next  = 1'b0;
                end
            end
        end

        held_calc = in_now_reg - start_next;

        if (in_now_reg < arm_after_reg) begin
            held_next = '0;
        end else if (!armed_reg) begin
            // held from boot: report stuck once, otherwise wait for a release
            if (stable_next && !deb_next) begin
                armed_next = 1'b1;
                held_next  = '0;
            end else if (stable_next && deb_next && !stuck_next &&
                         in_now_reg >= stuck_reg) begin
                stuck_next = 1'b1;
                ev_next    = lpbw_pkg::EV_STUCK;
            end else begin
                held_next = '0;
            end
        end else if (!stable_next || !deb_next) begin
            if (warned_next && !fired_next) begin
                ev_next = lpbw_pkg::EV_CANCELLED;
            end
            held_next   = '0;
            warned_next = 1'b0;
            fired_next  = 1'b0;
            stuck_next  = 1'b0;
        end else if (!stuck_next) begin
            held_next = held_calc;
            if (!fired_next && held_calc >= hold_reg) begin
                fired_next = 1'b1;
                ev_next    = lpbw_pkg::EV_FIRED;
            end else if (held_calc >= stuck_reg) begin
                stuck_next = 1'b1;
            end else if (!warned_next && held_calc >= warn_reg) begin
                warned_next = 1'b1;
                ev_next     = lpbw_pkg::EV_WARNING;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg     <= 1'b0;
            chg_reg     <= '0;
            stable_reg  <= 1'b0;
            deb_reg     <= 1'b0;
            start_reg   <= '0;
            armed_reg   <= 1'b0;
            warned_reg  <= 1'b0;
            fired_reg   <= 1'b0;
            stuck_reg_f <= 1'b0;
            held_reg    <= '0;
        end else if (advance) begin
            raw_reg     <= raw_next;
            chg_reg     <= chg_next;
            stable_reg  <= stable_next;
            deb_reg     <= deb_next;
            start_reg   <= start_next;
            armed_reg   <= armed_next;
            warned_reg  <= warned_next;
            fired_reg   <= fired_next;
            stuck_reg_f <= stuck_next;
            held_reg    <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ev_reg   <= ev_next;
            out_held_reg <= held_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_held_reg, out_ev_reg};

`ifndef SYNTHESIS
    // fired only once the hold time is reached
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev_next == lpbw_pkg::EV_FIRED) |-> (held_next >= hold_reg))
        else $error("fired before the hold time");

    // cancel only between warning and fired
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev_next == lpbw_pkg::EV_CANCELLED) |-> (warned_reg && !fired_reg))
        else $error("cancel without pending warning");

    // a nonzero hold time is only counted for an armed press (stuck report excepted)
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && held_next != '0 && ev_next != lpbw_pkg::EV_STUCK) |=> armed_reg)
        else $error("hold time counted while not armed");

    // an empty input register never stalls the source
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

[tb/sv/tb_long_press_button_watch_core.sv]
// Self-checking testbench for the long-press button watch core.
`timescale 1ns / 1ps

module tb_long_press_button_watch_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 300;
    localparam int SETTLE      = 4;
    // address index with no register behind it; writes must be ignored
    localparam logic [2:0] REG_SPARE = 3'd5;

    typedef struct {
        logic        pressed;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct {
        lpbw_pkg::event_t ev;
        logic [31:0]      held;
    } verdict_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lpbw_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lpbw_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [lpbw_pkg::ADDR_W-1:0]    paddr    = '0;
    logic [31:0]                    pwdata   = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    long_press_button_watch_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    sample_t  sample_q[$];
    verdict_t verdict_q[$];

    // timing registers as the core should hold them
    logic [lpbw_pkg::DEB_W-1:0]  debounce_cfg  = lpbw_pkg::DEBOUNCE_RST;
    logic [lpbw_pkg::TIME_W-1:0] arm_after_cfg = lpbw_pkg::ARM_AFTER_RST;
    logic [lpbw_pkg::TIME_W-1:0] warn_cfg      = lpbw_pkg::WARN_RST;
    logic [lpbw_pkg::TIME_W-1:0] hold_cfg      = lpbw_pkg::HOLD_RST;
    logic [lpbw_pkg::TIME_W-1:0] stuck_cfg     = lpbw_pkg::STUCK_RST;

    // button tracking state
    logic        raw_lvl    = 1'b0;
    logic [31:0] raw_since  = '0;
    logic        settled    = 1'b0;
    logic        deb_lvl    = 1'b0;
    logic [31:0] press_t0   = '0;
    logic        armed      = 1'b0;
    logic        warned     = 1'b0;
    logic        fired      = 1'b0;
    logic        stuck_flag = 1'b0;
    logic [31:0] held_ms    = '0;

    int          fail_count  = 0;
    int          cycle_count = 0;
    int          idle_pct    = 0;
    bit          quiet       = 1'b0;
    int          stall_reqs  = 0;
    int          stalls_done = 0;
    int          recv_gap    = 0;
    int          recv_hold   = 0;
    int          send_gap    = 0;
    sample_t     cur_smp;
    verdict_t    want;
    logic [31:0] stim_clock  = '0;

    // Debounce, arming and hold timing for one sample; queues the verdict it causes.
    task automatic watch_button(input logic smp, input logic [31:0] now);
        lpbw_pkg::event_t ev;
        logic [31:0]      since;
        ev = lpbw_pkg::EV_NONE;
        since = now - raw_since;
        if (smp != raw_lvl) begin
            raw_lvl = smp;
            raw_since = now;
            settled = 1'b0;
        end else if (!settled && since >= debounce_cfg) begin
            settled = 1'b1;
            if (deb_lvl != raw_lvl) begin
                deb_lvl = raw_lvl;
                if (deb_lvl) begin
                    press_t0 = now;
                    warned = 1'b0;
                    fired = 1'b0;
                    stuck_flag = 1'b0;
                end
            end
        end

        if (now < arm_after_cfg) begin
            held_ms = '0;
        end else if (!armed) begin
            if (settled && !deb_lvl) begin
                armed = 1'b1;
                held_ms = '0;
            end else if (settled && deb_lvl && !stuck_flag && now >= stuck_cfg) begin
                // held since boot: report once, held count untouched
                stuck_flag = 1'b1;
                ev = lpbw_pkg::EV_STUCK;
            end else begin
                held_ms = '0;
            end
        end else if (!settled || !deb_lvl) begin
            if (warned && !fired)
                ev = lpbw_pkg::EV_CANCELLED;
            held_ms = '0;
            warned = 1'b0;
            fired = 1'b0;
            stuck_flag = 1'b0;
        end else if (!stuck_flag) begin
            held_ms = now - press_t0;
            if (!fired && held_ms >= hold_cfg) begin
                fired = 1'b1;
                ev = lpbw_pkg::EV_FIRED;
            end else if (held_ms >= stuck_cfg) begin
                stuck_flag = 1'b1;
            end else if (!warned && held_ms >= warn_cfg) begin
                warned = 1'b1;
                ev = lpbw_pkg::EV_WARNING;
            end
        end
        verdict_q.push_back('{ev, held_ms});
    endtask

    task automatic note_mismatch(input string what, input logic [39:0] exp_v,
                                 input logic [39:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                watch_button(cur_smp.pressed, cur_smp.now_ms);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    cur_smp = sample_q.pop_front();
                    s_tdata <= {7'd0, cur_smp.now_ms, cur_smp.pressed};
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 99) < idle_pct)
                        send_gap = $urandom_range(1, 19);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    note_mismatch("unexpected transaction", '0, m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[2:0] !== want.ev)
                        note_mismatch("event_res", want.ev, m_tdata[2:0]);
                    if (m_tdata[34:3] !== want.held)
                        note_mismatch("held_time", want.held, m_tdata[34:3]);
                    if (m_tdata[39:35] !== '0)
                        note_mismatch("tdata padding", '0, m_tdata[39:35]);
                end
            end
            if (stalls_done < stall_reqs) begin
                stalls_done++;
                recv_hold = LONG_STALL;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                recv_gap = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_sample(input logic smp, input logic [31:0] now);
        sample_q.push_back('{smp, now});
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lpbw_pkg::REG_DEBOUNCE:  debounce_cfg  = val[lpbw_pkg::DEB_W-1:0];
            lpbw_pkg::REG_ARM_AFTER: arm_after_cfg = val;
            lpbw_pkg::REG_WARN:      warn_cfg      = val;
            lpbw_pkg::REG_HOLD:      hold_cfg      = val;
            lpbw_pkg::REG_STUCK:     stuck_cfg     = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [31:0] deb, input logic [31:0] arm,
                              input logic [31:0] warn, input logic [31:0] hold,
                              input logic [31:0] stuck);
        apb_write(lpbw_pkg::REG_DEBOUNCE, deb);
        apb_write(lpbw_pkg::REG_ARM_AFTER, arm);
        apb_write(lpbw_pkg::REG_WARN, warn);
        apb_write(lpbw_pkg::REG_HOLD, hold);
        apb_write(lpbw_pkg::REG_STUCK, stuck);
        @(negedge aclk);
    endtask

    // wait until every sample went in and every result came back
    task automatic drain();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // press/release runs with random step sizes, some bounce and some noise
    task automatic add_presses(input int count, input int unsigned step_max);
        int   made;
        int   run;
        logic lvl;
        made = 0;
        lvl = 1'b1;
        while (made < count) begin
            lvl = !lvl;
            run = lvl ? $urandom_range(1, 30) : $urandom_range(1, 8);
            for (int k = 0; k < run && made < count; k++) begin
                stim_clock += $urandom_range(0, step_max);
                if ($urandom_range(0, 9) == 0)
                    push_sample(1'($urandom_range(0, 1)), $urandom());
                else if ($urandom_range(0, 14) == 0)
                    push_sample(!lvl, stim_clock);
                else
                    push_sample(lvl, stim_clock);
                made++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset timing: boot window, stuck from boot, warn/cancel,
        // fired then late warning, stuck freeze, timestamp wrap
        idle_pct = 20;
        push_sample(1'b1, 32'd0);
        push_sample(1'b1, 32'd49);
        push_sample(1'b1, 32'd50);
        push_sample(1'b1, 32'd2999);
        push_sample(1'b1, 32'd3000);
        push_sample(1'b1, 32'd30000);
        push_sample(1'b1, 32'd30001);
        push_sample(1'b0, 32'd30010);
        push_sample(1'b0, 32'd30060);
        push_sample(1'b1, 32'd30100);
        push_sample(1'b1, 32'd30150);
        push_sample(1'b1, 32'd32150);
        push_sample(1'b0, 32'd32200);
        push_sample(1'b0, 32'd32250);
        push_sample(1'b1, 32'd32300);
        push_sample(1'b1, 32'd32350);
        push_sample(1'b1, 32'd42350);
        push_sample(1'b1, 32'd42351);
        push_sample(1'b1, 32'd62350);
        push_sample(1'b1, 32'd62400);
        push_sample(1'b0, 32'd62500);
        push_sample(1'b1, 32'hFFFF_FFF0);
        push_sample(1'b1, 32'h0000_0030);
        push_sample(1'b1, 32'd3000);
        push_sample(1'b1, 32'hFFFF_FFFF);
        drain();

        // reset timing, coarse steps
        idle_pct = 30;
        stim_clock = 32'd70000;
        add_presses(150, 800);
        drain();

        // short timing; the receiver holds off while samples pile up
        set_timing(5, 100, 60, 200, 500);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        stall_reqs++;
        add_presses(150, 40);
        drain();

        // all zero: every press fires at once, then sticks
        idle_pct = 0;
        set_timing(0, 0, 0, 0, 0);
        add_presses(100, 20);
        drain();

        // all maximum: boot window never ends short of the top value
        idle_pct = 50;
        set_timing(32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        stim_clock = 32'hFFFF_0000;
        add_presses(60, 30000);
        drain();

        // random timing, boot window reopened just ahead of the stream
        idle_pct = 20;
        repeat (3) begin
            set_timing($urandom_range(0, 100), stim_clock + $urandom_range(0, 300),
                       $urandom_range(0, 300), $urandom_range(0, 600),
                       $urandom_range(0, 900));
            add_presses(80, 50);
            drain();
        end

        // no idling, time wraps through zero into a boot window again
        quiet = 1'b1;
        set_timing(3, 200, 40, 120, 300);
        stim_clock = 32'hFFFF_FD00;
        add_presses(150, 25);
        drain();

        if (verdict_q.size() != 0) begin
            $display("results missing: %0d", verdict_q.size());
            fail_count += verdict_q.size();
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/lpbw_pkg.sv
rtl/core/long_press_button_watch_core.sv
tb/sv/tb_long_press_button_watch_core.sv
